@@ rtl/tma_pkg.sv @@
package tma_pkg;

	// Temperature format: unsigned degrees with six fraction bits.
	localparam int TEMP_W         = 15;
	localparam int FRAC_BITS      = 6;
	localparam int FULL_SCALE_DEG = 330;
	localparam int TEMP_FULL      = FULL_SCALE_DEG * (2 ** FRAC_BITS);
	localparam int SCALE_W        = 15;
	localparam int HYST_DEG       = 10;

	// Configuration register widths and reset values.
	localparam int ALARM_THR_W = 8;
	localparam int FAN_THR_W   = 9;
	localparam int HOLD_W      = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [ALARM_THR_W-1:0] ALARM_THR_RST = 8'd60;
	localparam logic [FAN_THR_W-1:0]   FAN_THR_RST   = 9'd45;
	localparam logic [HOLD_W-1:0]      FAN_HOLD_RST  = 16'd60;
	localparam logic [HOLD_W-1:0]      SEC_MAX       = '1;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_ALARM_THR = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FAN_THR   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FAN_HOLD  = 2'd2;

	// Item kinds.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

endpackage

@@ rtl/temperature_monitor_fan_alarm.sv @@
// An accepted word passes through the stage registers s1 to s7 in order; its result word
// is valid once it reaches s7 and is taken when out_stall is low.
// Throughput: one word per cycle unless out_stall holds; a stage loads when it is empty
// or its content moves on, so a waiting result blocks input only once all stages fill.
// Reset (arst_n low, asynchronous): stage valids, ring pointer, running sum, flags,
// seconds counter and configuration registers return to their reset values at once.
module temperature_monitor_fan_alarm #(
	parameter int WINDOW   = 10,
	parameter int ADC_BITS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input channel.
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             opcode,
	input  logic [ADC_BITS-1:0]              raw_sample,
	input  logic                             rf_active,
	// Result channel.
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             fan_on,
	output logic                             alarm,
	output logic                             rf_shutdown,
	output logic [tma_pkg::TEMP_W-1:0]       average_temp,
	output logic [tma_pkg::TEMP_W-1:0]       current_temp,
	// Configuration write port.
	input  logic                             cfg_wr_en,
	input  logic [tma_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tma_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tma_pkg::*;

	// Derived sizes. The conversion product is raw * full scale; the running sum must
	// hold WINDOW full-scale samples; the average uses a reciprocal of WINDOW scaled by
	// 2^SUM_W so that the estimate is at most one below the true quotient.
	localparam int ADC_MAX = (1 << ADC_BITS) - 1;
	localparam int X_W     = ADC_BITS + SCALE_W;
	localparam int IDX_W   = $clog2(WINDOW);
	localparam int SUM_W   = $clog2(TEMP_FULL * WINDOW + 1);
	localparam int PROD_W  = 2 * SUM_W;
	localparam int RECIP   = (2 ** SUM_W) / WINDOW;

	// Configuration registers.
	logic [ALARM_THR_W-1:0] alarm_thr_q;
	logic [FAN_THR_W-1:0]   fan_thr_q;
	logic [HOLD_W-1:0]      fan_hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_thr_q <= ALARM_THR_RST;
			fan_thr_q   <= FAN_THR_RST;
			fan_hold_q  <= FAN_HOLD_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ALARM_THR: alarm_thr_q <= cfg_data[ALARM_THR_W-1:0];
				REG_FAN_THR:   fan_thr_q   <= cfg_data[FAN_THR_W-1:0];
				REG_FAN_HOLD:  fan_hold_q  <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control. Each stage holds a valid bit; a stage may load when it is
	// empty or when the stage after it loads in the same cycle.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
	logic load1, load2, load3, load4, load5, load6, load7;

	assign rdy7 = !v_s7 || !out_stall;
	assign rdy6 = !v_s6 || rdy7;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign load1 = in_valid && rdy1;
	assign load2 = v_s1 && rdy2;
	assign load3 = v_s2 && rdy3;
	assign load4 = v_s3 && rdy4;
	assign load5 = v_s4 && rdy5;
	assign load6 = v_s5 && rdy6;
	assign load7 = v_s6 && rdy7;

	assign in_stall  = !rdy1;
	assign out_valid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
			if (rdy7) v_s7 <= v_s6;
		end
	end

	// Item kind and RF level travel alongside stages 1 to 6.
	logic op_s1, op_s2, op_s3, op_s4, op_s5, op_s6;
	logic rf_s1, rf_s2, rf_s3, rf_s4, rf_s5, rf_s6;

	// Stage 1: input register.
	logic [ADC_BITS-1:0] raw_s1;

	// Stage 2: product raw * full scale.
	logic [X_W-1:0] x_s2;

	// Stage 3: division of the product by the ADC full-scale code. Since the divisor is
	// 2^N - 1, the quotient is the sum of the product shifted by N, 2N, 3N, which falls
	// short by at most three; the remainder then picks the exact correction.
	logic [TEMP_W-1:0] q_est;
	logic [X_W-1:0]    q_times_max;
	logic [X_W-1:0]    conv_rem;
	logic [1:0]        conv_corr;
	logic [TEMP_W-1:0] t_conv;
	logic [TEMP_W-1:0] t_s3;

	always_comb begin
		q_est = TEMP_W'(x_s2 >> ADC_BITS) + TEMP_W'(x_s2 >> (2 * ADC_BITS))
			+ TEMP_W'(x_s2 >> (3 * ADC_BITS));
		q_times_max = {q_est, {ADC_BITS{1'b0}}} - X_W'(q_est);
		conv_rem    = x_s2 - q_times_max;
		conv_corr   = {1'b0, conv_rem >= X_W'(ADC_MAX)}
			+ {1'b0, conv_rem >= X_W'(2 * ADC_MAX)}
			+ {1'b0, conv_rem >= X_W'(3 * ADC_MAX)};
		t_conv = q_est + TEMP_W'(conv_corr);
	end

	// Stage 4: sample ring and running sum. The first sample after reset fills the whole
	// ring, so the average starts at that sample instead of ramping up from zero.
	logic [TEMP_W-1:0] ring_q [WINDOW];
	logic [IDX_W-1:0]  idx_q;
	logic [SUM_W-1:0]  sum_q;
	logic              primed_q;
	logic [TEMP_W-1:0] last_q;

	logic [IDX_W-1:0]  idx_base;
	logic [IDX_W-1:0]  idx_nxt;
	logic [SUM_W-1:0]  sum_nxt;
	logic              sample_in4;

	logic [SUM_W-1:0]  sum_s4;
	logic [TEMP_W-1:0] temp_s4;

	always_comb begin
		sample_in4 = load4 && (op_s3 == OP_SAMPLE);
		idx_base   = primed_q ? idx_q : '0;
		idx_nxt    = (idx_base == IDX_W'(WINDOW - 1)) ? '0 : idx_base + 1'b1;
		if (primed_q) begin
			sum_nxt = sum_q - SUM_W'(ring_q[idx_q]) + SUM_W'(t_s3);
		end else begin
			sum_nxt = SUM_W'(t_s3) * SUM_W'(WINDOW);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			sum_q    <= '0;
			primed_q <= 1'b0;
			last_q   <= '0;
		end else if (sample_in4) begin
			idx_q    <= idx_nxt;
			sum_q    <= sum_nxt;
			primed_q <= 1'b1;
			last_q   <= t_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_in4) begin
			if (!primed_q) begin
				for (int i = 0; i < WINDOW; i++) begin
					ring_q[i] <= t_s3;
				end
			end else begin
				ring_q[idx_q] <= t_s3;
			end
		end
	end

	// Stage 5: reciprocal multiply, an estimate of sum / WINDOW.
	logic [PROD_W-1:0] avg_prod;
	logic [TEMP_W-1:0] q0_s5;
	logic [SUM_W-1:0]  sum_s5;
	logic [TEMP_W-1:0] temp_s5;

	assign avg_prod = PROD_W'(sum_s4) * PROD_W'(RECIP);

	// Stage 6: exact average and the threshold comparisons.
	logic [SUM_W-1:0]  q0_times_win;
	logic [SUM_W-1:0]  avg_rem;
	logic [TEMP_W-1:0] avg_exact;
	logic [TEMP_W-1:0] alarm_level;
	logic [TEMP_W-1:0] clear_level;
	logic [TEMP_W-1:0] fan_level;
	logic              hot_cmp, cool_cmp, fan_cmp;

	logic [TEMP_W-1:0] avg_s6;
	logic [TEMP_W-1:0] temp_s6;
	logic              hot_s6, cool_s6, fan_hot_s6;

	always_comb begin
		q0_times_win = SUM_W'(q0_s5) * SUM_W'(WINDOW);
		avg_rem      = sum_s5 - q0_times_win;
		avg_exact    = q0_s5 + TEMP_W'(avg_rem >= SUM_W'(WINDOW));
		alarm_level  = TEMP_W'({alarm_thr_q, {FRAC_BITS{1'b0}}});
		clear_level  = TEMP_W'({alarm_thr_q - ALARM_THR_W'(HYST_DEG), {FRAC_BITS{1'b0}}});
		fan_level    = TEMP_W'({fan_thr_q, {FRAC_BITS{1'b0}}});
		hot_cmp      = temp_s5 >= alarm_level;
		// With a threshold below the hysteresis the clear level would be negative, so
		// the alarm then never clears.
		cool_cmp     = (alarm_thr_q >= ALARM_THR_W'(HYST_DEG)) && (avg_exact < clear_level);
		fan_cmp      = avg_exact >= fan_level;
	end

	// Stage 7: alarm, fan and seconds state; these registers are also the result levels.
	logic              alarm_q;
	logic              shutdown_sent_q;
	logic              fan_q;
	logic [HOLD_W-1:0] sec_q;

	logic [TEMP_W-1:0] avg_s7;
	logic [TEMP_W-1:0] temp_s7;
	logic              pulse_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q         <= 1'b0;
			shutdown_sent_q <= 1'b0;
			fan_q           <= 1'b0;
			sec_q           <= '0;
			pulse_s7        <= 1'b0;
		end else if (load7) begin
			pulse_s7 <= 1'b0;
			if (op_s6 == OP_TICK) begin
				if (sec_q != SEC_MAX) begin
					sec_q <= sec_q + 1'b1;
				end
			end else begin
				if (hot_s6) begin
					alarm_q <= 1'b1;
					if (!shutdown_sent_q) begin
						shutdown_sent_q <= 1'b1;
						pulse_s7        <= 1'b1;
					end
				end else if (cool_s6) begin
					alarm_q <= 1'b0;
				end
				// The fan stays on while RF runs even after the hold time; the counter
				// then parks at the hold time.
				if (fan_hot_s6) begin
					fan_q <= 1'b1;
					sec_q <= '0;
				end else if (sec_q >= fan_hold_q) begin
					if (!rf_s6) begin
						fan_q <= 1'b0;
					end
					sec_q <= fan_hold_q;
				end
			end
		end
	end

	// Payload registers of all stages.
	always_ff @(posedge clk) begin
		if (load1) begin
			op_s1  <= opcode;
			rf_s1  <= rf_active;
			raw_s1 <= raw_sample;
		end
		if (load2) begin
			op_s2 <= op_s1;
			rf_s2 <= rf_s1;
			x_s2  <= X_W'(raw_s1) * X_W'(TEMP_FULL);
		end
		if (load3) begin
			op_s3 <= op_s2;
			rf_s3 <= rf_s2;
			t_s3  <= t_conv;
		end
		if (load4) begin
			op_s4 <= op_s3;
			rf_s4 <= rf_s3;
			if (op_s3 == OP_SAMPLE) begin
				sum_s4  <= sum_nxt;
				temp_s4 <= t_s3;
			end else begin
				sum_s4  <= sum_q;
				temp_s4 <= last_q;
			end
		end
		if (load5) begin
			op_s5   <= op_s4;
			rf_s5   <= rf_s4;
			q0_s5   <= avg_prod[SUM_W +: TEMP_W];
			sum_s5  <= sum_s4;
			temp_s5 <= temp_s4;
		end
		if (load6) begin
			op_s6      <= op_s5;
			rf_s6      <= rf_s5;
			avg_s6     <= avg_exact;
			temp_s6    <= temp_s5;
			hot_s6     <= hot_cmp;
			cool_s6    <= cool_cmp;
			fan_hot_s6 <= fan_cmp;
		end
		if (load7) begin
			avg_s7  <= avg_s6;
			temp_s7 <= temp_s6;
		end
	end

	assign fan_on       = fan_q;
	assign alarm        = alarm_q;
	assign rf_shutdown  = pulse_s7;
	assign average_temp = avg_s7;
	assign current_temp = temp_s7;

endmodule

@@ sim/testbench.sv @@
localparam int RING_DEPTH = 10;
localparam int ADC_W      = 10;
localparam int ADC_FULL   = (1 << ADC_W) - 1;

typedef struct packed {
	logic                        fan_on;
	logic                        alarm;
	logic                        rf_shutdown;
	logic [tma_pkg::TEMP_W-1:0]  average_temp;
	logic [tma_pkg::TEMP_W-1:0]  current_temp;
} temp_report_t;

class thermal_scoreboard;
	logic [tma_pkg::ALARM_THR_W-1:0] alarm_thr;
	logic [tma_pkg::FAN_THR_W-1:0]   fan_thr;
	logic [tma_pkg::HOLD_W-1:0]      hold_secs;
	int unsigned                     history [RING_DEPTH];
	int unsigned                     slot;
	int unsigned                     history_sum;
	int unsigned                     latest;
	bit                              primed;
	bit                              alarm_on;
	bit                              shutdown_sent;
	bit                              fan_running;
	logic [tma_pkg::HOLD_W-1:0]      seconds;
	temp_report_t                    predicted_reports [$];
	int                              mismatches;
	int                              compared;
	int                              pulses;

	function new();
		alarm_thr = tma_pkg::ALARM_THR_RST;
		fan_thr = tma_pkg::FAN_THR_RST;
		hold_secs = tma_pkg::FAN_HOLD_RST;
		foreach (history[i])
			history[i] = 0;
		slot = 0;
		history_sum = 0;
		latest = 0;
		primed = 0;
		alarm_on = 0;
		shutdown_sent = 0;
		fan_running = 0;
		seconds = '0;
		mismatches = 0;
		compared = 0;
		pulses = 0;
	endfunction

	function void set_register(logic [tma_pkg::CFG_INDEX_W-1:0] idx,
			logic [tma_pkg::CFG_DATA_W-1:0] value);
		case (idx)
			tma_pkg::REG_ALARM_THR: alarm_thr = value[tma_pkg::ALARM_THR_W-1:0];
			tma_pkg::REG_FAN_THR:   fan_thr = value[tma_pkg::FAN_THR_W-1:0];
			tma_pkg::REG_FAN_HOLD:  hold_secs = value[tma_pkg::HOLD_W-1:0];
			default: ;
		endcase
	endfunction

	function int pending();
		return predicted_reports.size();
	endfunction

	// Works out the report for one accepted word and queues it.
	function void note_word(logic op, logic [ADC_W-1:0] raw, logic rf);
		temp_report_t want;
		int unsigned  t;
		int unsigned  avg;
		int unsigned  start;
		bit           pulse;
		pulse = 0;
		if (op == tma_pkg::OP_TICK) begin
			if (seconds != tma_pkg::SEC_MAX)
				seconds++;
		end else begin
			t = (32'(raw) * tma_pkg::TEMP_FULL) / ADC_FULL;
			start = (slot >= RING_DEPTH) ? 0 : slot;
			if (!primed) begin
				primed = 1;
				foreach (history[i])
					history[i] = t;
				history_sum = t * RING_DEPTH;
				start = 0;
			end else begin
				history_sum = history_sum - history[start] + t;
				history[start] = t;
			end
			latest = t;
			avg = history_sum / RING_DEPTH;
			if (t >= (32'(alarm_thr) << tma_pkg::FRAC_BITS)) begin
				alarm_on = 1;
				if (!shutdown_sent) begin
					shutdown_sent = 1;
					pulse = 1;
				end
			end else if (alarm_thr >= tma_pkg::HYST_DEG &&
					avg < ((32'(alarm_thr) - tma_pkg::HYST_DEG) << tma_pkg::FRAC_BITS)) begin
				alarm_on = 0;
			end
			slot = (start + 1 >= RING_DEPTH) ? 0 : start + 1;
			if (avg >= (32'(fan_thr) << tma_pkg::FRAC_BITS)) begin
				fan_running = 1;
				seconds = '0;
			end else if (seconds >= hold_secs) begin
				if (!rf)
					fan_running = 0;
				seconds = hold_secs;
			end
		end
		avg = history_sum / RING_DEPTH;
		want.fan_on = fan_running;
		want.alarm = alarm_on;
		want.rf_shutdown = pulse;
		want.average_temp = avg[tma_pkg::TEMP_W-1:0];
		want.current_temp = latest[tma_pkg::TEMP_W-1:0];
		predicted_reports.push_back(want);
	endfunction

	function void compare_field(string name, longint unsigned stamp,
			int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0d ns: %s mismatch, expected %0d, got %0d", stamp, name, want, got);
			mismatches++;
		end
	endfunction

	function void check_report(temp_report_t got, longint unsigned stamp);
		temp_report_t want;
		if (predicted_reports.size() == 0) begin
			$display("%0d ns: unexpected result word, expected none, got %h", stamp, got);
			mismatches++;
			return;
		end
		want = predicted_reports.pop_front();
		compared++;
		if (got.rf_shutdown)
			pulses++;
		compare_field("fan_on", stamp, 32'(want.fan_on), 32'(got.fan_on));
		compare_field("alarm", stamp, 32'(want.alarm), 32'(got.alarm));
		compare_field("rf_shutdown", stamp, 32'(want.rf_shutdown), 32'(got.rf_shutdown));
		compare_field("average_temp", stamp, 32'(want.average_temp),
			32'(got.average_temp));
		compare_field("current_temp", stamp, 32'(want.current_temp),
			32'(got.current_temp));
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tma_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES      = 6;
	localparam int PHASE_WORDS = 88;
	// Margin waited after the last result before touching registers.
	localparam int SETTLE      = 12;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   opcode = OP_SAMPLE;
	logic [ADC_W-1:0]       raw_sample = '0;
	logic                   rf_active = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   fan_on;
	logic                   alarm;
	logic                   rf_shutdown;
	logic [TEMP_W-1:0]      average_temp;
	logic [TEMP_W-1:0]      current_temp;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_ALARM_THR;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	thermal_scoreboard sb = new();

	// When calm is set, neither side inserts gaps or stalls.
	bit  calm = 1'b0;
	int  cycles = 0;
	int  stall_left = 0;
	int  sample_count = 0;
	int  tick_count = 0;
	int  setting_count = 0;
	// Temperature in whole degrees that the current run of samples hovers around.
	int  target_deg = 0;
	int  run_left = 0;

	temperature_monitor_fan_alarm #(
		.WINDOW(RING_DEPTH),
		.ADC_BITS(ADC_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.raw_sample(raw_sample),
		.rf_active(rf_active),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fan_on(fan_on),
		.alarm(alarm),
		.rf_shutdown(rf_shutdown),
		.average_temp(average_temp),
		.current_temp(current_temp),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin
		while (cycles < CYCLE_LIMIT)
			@(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	// Every result word taken at an edge is checked against the oldest prediction.
	// Values are read right at the edge, before any update of that edge lands.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_report({fan_on, alarm, rf_shutdown, average_temp, current_temp}, $time);
	end

	// Receiver back-pressure: runs of ready cycles, short stalls and the odd long one.
	always @(posedge clk) begin : stall_gen
		int pick;
		if (calm) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				out_stall <= 1'b0;
				stall_left = $urandom_range(0, 10);
			end else if (pick < 92) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(8, 40);
			end
		end
	end

	function automatic int gap_length();
		int pick;
		if (calm)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// ADC code for a temperature near the target of the current run, with some
	// plain noise mixed in. The inverse of the conversion is only approximate,
	// which is fine since the jitter spreads the codes anyway.
	function automatic logic [ADC_W-1:0] sample_code();
		int deg;
		int code;
		if ($urandom_range(0, 3) == 0)
			return ADC_W'($urandom_range(0, ADC_FULL));
		deg = target_deg + int'($urandom_range(0, 16)) - 8;
		code = (deg * ADC_FULL) / FULL_SCALE_DEG + int'($urandom_range(0, 6)) - 3;
		if (code < 0)
			code = 0;
		if (code > ADC_FULL)
			code = ADC_FULL;
		return code[ADC_W-1:0];
	endfunction

	// Picks where the next run of samples sits: above the alarm level, below its
	// clear level, around the fan level, or anywhere.
	function automatic void new_run();
		case ($urandom_range(0, 4))
			0: target_deg = int'(sb.alarm_thr) + 6;
			1: target_deg = int'(sb.alarm_thr) - 16;
			2: target_deg = int'(sb.fan_thr) + 4;
			3: target_deg = int'(sb.fan_thr) - 4;
			default: target_deg = $urandom_range(0, FULL_SCALE_DEG);
		endcase
		run_left = $urandom_range(5, 20);
	endfunction

	task automatic pause(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Presents one word and holds it until the block takes it.
	task automatic send_word(input logic op, input logic [ADC_W-1:0] raw, input logic rf);
		in_valid <= 1'b1;
		opcode <= op;
		raw_sample <= raw;
		rf_active <= rf;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_word(op, raw, rf);
		if (op == OP_TICK)
			tick_count++;
		else
			sample_count++;
		pause(gap_length());
	endtask

	// Stops sending and waits until every predicted result has been seen.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Register writes happen only with the block empty.
	task automatic apply_settings(input int alarm_deg, input int fan_deg, input int hold);
		logic [CFG_INDEX_W-1:0] regs [3];
		logic [CFG_DATA_W-1:0]  vals [3];
		regs = '{REG_ALARM_THR, REG_FAN_THR, REG_FAN_HOLD};
		vals = '{alarm_deg[CFG_DATA_W-1:0], fan_deg[CFG_DATA_W-1:0], hold[CFG_DATA_W-1:0]};
		drain();
		for (int i = 0; i < 3; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_register(regs[i], vals[i]);
		end
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		setting_count++;
	endtask

	initial begin
		int alarm_deg;
		int fan_deg;
		int hold;
		int burst;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a tick before any sample must report zero temperatures,
		// then the first sample fills the whole ring. Full-scale samples raise the
		// alarm and the one-time shutdown pulse, and repeat without a second pulse.
		send_word(OP_TICK, '1, 1'b0);
		send_word(OP_SAMPLE, '0, 1'b1);
		repeat (3) send_word(OP_SAMPLE, '1, 1'b0);
		send_word(OP_SAMPLE, 10'h2AA, 1'b1);
		send_word(OP_SAMPLE, 10'h155, 1'b0);

		// Alarm level below ten degrees, so the alarm can never clear, and a zero
		// hold time, so the fan may drop on any sample under its threshold unless
		// RF is running. The fan threshold is at full scale.
		apply_settings(9, FULL_SCALE_DEG, 0);
		send_word(OP_SAMPLE, '1, 1'b0);
		send_word(OP_SAMPLE, '0, 1'b1);
		repeat (2) send_word(OP_SAMPLE, '0, 1'b0);
		send_word(OP_TICK, '0, 1'b1);

		// Fan threshold zero keeps the fan on; alarm at the top of its range.
		apply_settings(255, 0, 3);
		send_word(OP_SAMPLE, '0, 1'b0);
		send_word(OP_SAMPLE, '1, 1'b0);
		send_word(OP_TICK, '0, 1'b0);

		// A long hold time and an unreachable fan threshold: ticks carry the seconds
		// counter past the hold time, RF then keeps the fan on once while the counter
		// parks at the hold time, and the next sample drops the fan.
		apply_settings(10, (1 << FAN_THR_W) - 1, 40);
		calm = 1'b1;
		repeat (45) send_word(OP_TICK, ADC_W'($urandom_range(0, ADC_FULL)), 1'b0);
		calm = 1'b0;
		send_word(OP_SAMPLE, '1, 1'b1);
		send_word(OP_SAMPLE, '0, 1'b0);
		send_word(OP_SAMPLE, '1, 1'b0);

		// Random phases. Samples come in runs around the thresholds so that the
		// alarm sets and clears through its hysteresis and the fan cycles through
		// its hold time; ticks come singly and in bursts.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				1: begin
					alarm_deg = 0;
					fan_deg = 0;
					hold = 1;
				end
				4: begin
					alarm_deg = 255;
					fan_deg = $urandom_range(200, FULL_SCALE_DEG);
					hold = $urandom_range(0, 2);
				end
				default: begin
					alarm_deg = $urandom_range(10, 120);
					fan_deg = $urandom_range(20, alarm_deg + 20);
					hold = $urandom_range(1, 20);
				end
			endcase
			apply_settings(alarm_deg, fan_deg, hold);
			calm = ($urandom_range(0, 4) == 0);
			run_left = 0;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (run_left == 0)
					new_run();
				if ($urandom_range(0, 99) < 30) begin
					send_word(OP_TICK, ADC_W'($urandom_range(0, ADC_FULL)),
						1'($urandom_range(0, 1)));
				end else begin
					send_word(OP_SAMPLE, sample_code(), $urandom_range(0, 2) == 0);
					run_left--;
				end
				if ($urandom_range(0, 99) < 4) begin
					burst = $urandom_range(1, 25);
					repeat (burst)
						send_word(OP_TICK, ADC_W'($urandom_range(0, ADC_FULL)), 1'b0);
				end
				// Once mid-run, let the block empty completely before going on.
				if (ph == 2 && n == PHASE_WORDS / 2)
					drain();
			end
		end

		drain();
		if (sb.pending() != 0) begin
			$display("%0d ns: %0d results never arrived, expected 0 outstanding", $time,
				sb.pending());
			sb.mismatches++;
		end
		$display("Covered %0d samples and %0d ticks over %0d register settings.",
			sample_count, tick_count, setting_count);
		$display("Checked %0d result words, %0d shutdown pulses seen, %0d mismatches.",
			sb.compared, sb.pulses, sb.mismatches);
		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ temperature_monitor_fan_alarm.f @@
rtl/tma_pkg.sv
rtl/temperature_monitor_fan_alarm.sv
sim/testbench.sv
